// ----- rtl/core/ght_pkg.sv -----
// ----------------------------------------------------------------------------
// ght_pkg
// Types and constants shared by the generational handle table core.
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

  localparam int unsigned SLOTS  = 1024;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned GEN_W  = 16;
  localparam int unsigned PAY_W  = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } ght_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/ght_if.sv -----
// ----------------------------------------------------------------------------
// ght_req_if / ght_rsp_if
// Valid/ready channels for table requests and their responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface ght_req_if
  import ght_pkg::*;
();

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] slot_index;
  logic [GEN_W-1:0] handle_generation;
  logic [PAY_W-1:0] payload;

  modport source (
    output valid, opcode, slot_index, handle_generation, payload,
    input  ready
  );

  modport sink (
    input  valid, opcode, slot_index, handle_generation, payload,
    output ready
  );
endinterface

interface ght_rsp_if
  import ght_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  result_index;
  logic [GEN_W-1:0]  result_generation;
  logic [PAY_W-1:0]  result_payload;

  modport source (
    output valid, status, result_index, result_generation, result_payload,
    input  ready
  );

  modport sink (
    input  valid, status, result_index, result_generation, result_payload,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/ght_ctrl.sv -----
// ----------------------------------------------------------------------------
// ght_ctrl
// Request sequencer: capture an item, then commit it into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ctrl
  import ght_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output ght_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cmd_o       = '{capture: in_valid_i && in_ready_o,
                         commit:  (state_q == S_EXEC) && slot_free};
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.capture) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ght_dpath.sv -----
// ----------------------------------------------------------------------------
// ght_dpath
// Slot memories, free list, allocation counter and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_dpath
  import ght_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ght_cmd_t          cmd_i,
  input  wire logic [OP_W-1:0]   opcode_i,
  input  wire logic [IDX_W-1:0]  slot_index_i,
  input  wire logic [GEN_W-1:0]  handle_generation_i,
  input  wire logic [PAY_W-1:0]  payload_i,
  output logic [STAT_W-1:0]      status_o,
  output logic [IDX_W-1:0]       result_index_o,
  output logic [GEN_W-1:0]       result_generation_o,
  output logic [PAY_W-1:0]       result_payload_o
);

  logic [IDX_W:0]   link_mem [SLOTS];
  logic [GEN_W-1:0] gen_mem  [SLOTS];
  logic             occ_mem  [SLOTS];
  logic [PAY_W-1:0] pay_mem  [SLOTS];

  logic [IDX_W:0]   link_rd_q;
  logic [GEN_W-1:0] gen_rd_q;
  logic             occ_rd_q;
  logic [PAY_W-1:0] pay_rd_q;

  opcode_e          op_q;
  logic [IDX_W-1:0] idx_q;
  logic [GEN_W-1:0] hgen_q;
  logic [PAY_W-1:0] pay_q;

  logic [CNT_W-1:0] used_q, used_d;
  logic [IDX_W-1:0] fh_q, fh_d;
  logic             fh_valid_q, fh_valid_d;

  logic [IDX_W-1:0] rd_addr;
  logic             full, alloc_ok, handle_ok, in_range;
  logic [IDX_W-1:0] alloc_idx, wr_idx;
  logic             is_alloc, is_free;
  logic             link_we, gen_we, occ_we, pay_we;
  logic [GEN_W-1:0] gen_wd;

  status_e          stat_d;
  logic [IDX_W-1:0] ridx_d;
  logic [GEN_W-1:0] rgen_d;
  logic [PAY_W-1:0] rpay_d;
  logic [STAT_W-1:0] stat_q;
  logic [IDX_W-1:0] ridx_q;
  logic [GEN_W-1:0] rgen_q;
  logic [PAY_W-1:0] rpay_q;

  assign rd_addr = (opcode_e'(opcode_i) == OP_ALLOC) ? fh_q : slot_index_i;

  assign full      = (used_q == CNT_W'(SLOTS));
  assign alloc_ok  = fh_valid_q || !full;
  assign alloc_idx = fh_valid_q ? fh_q : used_q[IDX_W-1:0];
  assign in_range  = ({1'b0, idx_q} < used_q);
  assign handle_ok = in_range && occ_rd_q && (gen_rd_q == hgen_q);

  assign is_alloc = cmd_i.commit && (op_q == OP_ALLOC) && alloc_ok;
  assign is_free  = cmd_i.commit && (op_q == OP_FREE) && handle_ok;

  assign wr_idx  = is_alloc ? alloc_idx : idx_q;
  assign link_we = is_free;
  assign gen_we  = is_free || (is_alloc && !fh_valid_q);
  assign gen_wd  = is_free ? gen_rd_q + GEN_W'(1) : '0;
  assign occ_we  = is_alloc || is_free;
  assign pay_we  = is_alloc;

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[wr_idx] <= {fh_valid_q, fh_q};
    end
    if (cmd_i.capture) begin
      link_rd_q <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[wr_idx] <= gen_wd;
    end
    if (cmd_i.capture) begin
      gen_rd_q <= gen_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[wr_idx] <= is_alloc;
    end
    if (cmd_i.capture) begin
      occ_rd_q <= occ_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[wr_idx] <= pay_q;
    end
    if (cmd_i.capture) begin
      pay_rd_q <= pay_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_e'(opcode_i);
      idx_q  <= slot_index_i;
      hgen_q <= handle_generation_i;
      pay_q  <= payload_i;
    end
  end

  always_comb begin
    used_d     = used_q;
    fh_d       = fh_q;
    fh_valid_d = fh_valid_q;
    if (cmd_i.commit) begin
      case (op_q)
        OP_ALLOC: begin
          if (fh_valid_q) begin
            fh_valid_d = link_rd_q[IDX_W];
            fh_d       = link_rd_q[IDX_W-1:0];
          end else if (!full) begin
            used_d = used_q + CNT_W'(1);
          end
        end
        OP_FREE: begin
          if (handle_ok) begin
            fh_d       = idx_q;
            fh_valid_d = 1'b1;
          end
        end
        OP_CLEAR: begin
          used_d     = '0;
          fh_valid_d = 1'b0;
        end
        default: begin
          used_d = used_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      fh_q       <= '0;
      fh_valid_q <= 1'b0;
    end else begin
      used_q     <= used_d;
      fh_q       <= fh_d;
      fh_valid_q <= fh_valid_d;
    end
  end

  always_comb begin
    stat_d = STAT_OK;
    ridx_d = idx_q;
    rgen_d = '0;
    rpay_d = '0;
    case (op_q)
      OP_ALLOC: begin
        if (alloc_ok) begin
          ridx_d = alloc_idx;
          rgen_d = fh_valid_q ? gen_rd_q : '0;
        end else begin
          stat_d = STAT_FULL;
        end
      end
      OP_FREE: begin
        if (!handle_ok) begin
          stat_d = STAT_INVALID;
        end
      end
      OP_LOOKUP: begin
        if (handle_ok) begin
          rgen_d = gen_rd_q;
          rpay_d = pay_rd_q;
        end else begin
          stat_d = STAT_INVALID;
        end
      end
      default: begin
        stat_d = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      stat_q <= stat_d;
      ridx_q <= ridx_d;
      rgen_q <= rgen_d;
      rpay_q <= rpay_d;
    end
  end

  assign status_o            = stat_q;
  assign result_index_o      = ridx_q;
  assign result_generation_o = rgen_q;
  assign result_payload_o    = rpay_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(SLOTS))
    else $error("allocation count beyond table size");

  a_head_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fh_valid_q |-> ({1'b0, fh_q} < used_q))
    else $error("free-list head outside appended slots");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (op_q == OP_CLEAR)) |=> ((used_q == '0) && !fh_valid_q))
    else $error("clear left table state behind");

endmodule

`default_nettype wire

// ----- rtl/core/generational_handle_table_core.sv -----
// ----------------------------------------------------------------------------
// generational_handle_table_core
// Handle table with per-slot generations and a free list of released slots.
//
// Requests arrive on req (opcode, slot_index, handle_generation, payload);
// each yields exactly one response on rsp (status, result_index,
// result_generation, result_payload). Opcodes: allocate, free, lookup, clear.
// A request transfer registers a read of the slot memories at the free-list
// head (allocate) or at slot_index; the update step then checks the handle,
// updates the memories and loads the response register, and rsp.valid rises.
// A new request is taken only after the previous one has loaded the response
// register, since the registered read of the slot memories precedes each
// update. req.ready is high whenever no request is in flight, also while a
// response waits on rsp. If rsp.ready stays low, the pending request holds in
// its update step and req.ready stays low until the waiting response is taken.
// Reset empties the table (no slots in use, free list empty) and drops any
// pending response; slot memories are not cleared and need no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table_core
  import ght_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ght_req_if.sink   req,
  ght_rsp_if.source rsp
);

  ght_cmd_t cmd;

  ght_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .cmd_o       (cmd)
  );

  ght_dpath u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .opcode_i            (req.opcode),
    .slot_index_i        (req.slot_index),
    .handle_generation_i (req.handle_generation),
    .payload_i           (req.payload),
    .status_o            (rsp.status),
    .result_index_o      (rsp.result_index),
    .result_generation_o (rsp.result_generation),
    .result_payload_o    (rsp.result_payload)
  );

endmodule

`default_nettype wire
